[design/rocket_recovery_sequencer_top_macros.svh]
// assertion helpers
`ifndef ROCKET_RECOVERY_SEQUENCER_TOP_MACROS_SVH
`define ROCKET_RECOVERY_SEQUENCER_TOP_MACROS_SVH
`define RRS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

[design/rrs_pkg.sv]
`default_nettype none
package rrs_pkg;
	typedef struct packed {
		logic        sensor_event;
		logic        linear_update;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic        switch_level;
		logic [31:0] now_ms;
	} rrs_in_t;

	typedef struct packed {
		logic [3:0]  flight_state;
		logic        coast_phase;
		logic        pyro_one;
		logic        pyro_two;
		logic        baro_record;
		logic        log_enable;
		logic [15:0] accel_magnitude;
		logic [15:0] accel_average;
	} rrs_out_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'd0, ST_ARMED = 4'd1, ST_LAUNCH = 4'd2, ST_COAST = 4'd3,
		ST_FIRE1 = 4'd4, ST_HOLD1 = 4'd5, ST_FIRE2 = 4'd6, ST_HOLD2 = 4'd7,
		ST_PRESERVE = 4'd8, ST_LANDING = 4'd9, ST_LANDED = 4'd10
	} rrs_state_t;

	typedef enum logic [2:0] {
		CFG_LAUNCH = 3'd0, CFG_APOGEE = 3'd1, CFG_LANDING = 3'd2, CFG_COAST = 3'd3,
		CFG_LOCKOUT = 3'd4, CFG_HOLD1 = 3'd5, CFG_HOLD2 = 3'd6
	} rrs_cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SQUARE, PH_SUM, PH_ROOT, PH_WIN, PH_SEQ, PH_DIV, PH_OUT
	} rrs_phase_t;
endpackage
`default_nettype wire

[design/rocket_recovery_sequencer_top.sv]
// A request with a sensor event passes, between acceptance and the next acceptance,
// through squaring on three parallel lanes, a merge add, the 17-step bit-serial
// square root, a window memory update, the sequence step, a reciprocal multiply for
// the window average and the output load; a request without an event goes straight
// to the sequence step. Results wait in an output register while the next request
// may be accepted; a stalled result holds the following one in the output stage.
// After reset every window memory entry is cleared before the first request is taken.
`default_nettype none
module rocket_recovery_sequencer_top #(
	parameter int WINDOW = 100
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire rrs_pkg::rrs_in_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rrs_pkg::rrs_out_t   out_data,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [15:0]    cfg_data
);
	import rrs_pkg::*;
	`include "rocket_recovery_sequencer_top_macros.svh"

	localparam int PW = $clog2(WINDOW);
	localparam int SW = 16 + $clog2(WINDOW + 1);
	localparam logic [31:0] RECIP = 32'(((64'd1 << 32) + 64'(WINDOW - 1)) / 64'(WINDOW));

	logic [15:0] thr_q [7];
	rrs_phase_t ph_q, ph_d;
	rrs_in_t    req_q;
	rrs_state_t st_q;
	logic [3:0] start_st_q;
	logic coast_q, rec_q, p1_q, p2_q;
	logic [31:0] launch_q, charge_q;
	logic signed [15:0] acc_q [3];
	logic [31:0] sq [3];
	logic [33:0] sq_sum;
	logic [15:0] mag_q;
	logic [15:0] win_q [WINDOW];
	logic [PW-1:0] ptr_q;
	logic [SW-1:0] wsum_q;
	logic [15:0] old_q;
	logic clr_q;
	logic [PW:0] clr_cnt_q;
	logic root_start, root_busy;
	logic [15:0] root;
	logic [SW+31:0] avg_prod;
	logic [15:0] quo_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q[CFG_LAUNCH] <= 16'd5120; thr_q[CFG_APOGEE] <= 16'd1280;
			thr_q[CFG_LANDING] <= 16'd256; thr_q[CFG_COAST] <= 16'd16000;
			thr_q[CFG_LOCKOUT] <= 16'd5000; thr_q[CFG_HOLD1] <= 16'd2000;
			thr_q[CFG_HOLD2] <= 16'd1000;
		end else if (cfg_valid && cfg_index <= CFG_HOLD2) begin
			thr_q[cfg_index] <= cfg_data;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		rrs_square_lane u_lane (.clk(clk), .en(ph_q == PH_SQUARE), .a(acc_q[k]), .sq_q(sq[k]));
	end

	assign sq_sum = 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]);
	assign root_start = (ph_q == PH_SUM);
	rrs_root u_root (.clk(clk), .arst_n(arst_n), .start(root_start), .value(sq_sum),
		.busy(root_busy), .root_q(root));

	function automatic logic [SW+17:0] scale(input logic [15:0] t);
		return (SW+18)'(t) * (SW+18)'(WINDOW);
	endfunction
	logic ab_launch, bl_apo, bl_land;
	assign ab_launch = (SW+18)'(wsum_q) > scale(thr_q[CFG_LAUNCH]);
	assign bl_apo    = (SW+18)'(wsum_q) < scale(thr_q[CFG_APOGEE]);
	assign bl_land   = (SW+18)'(wsum_q) < scale(thr_q[CFG_LANDING]);
	logic [31:0] dt_l, dt_c;
	assign dt_l = req_q.now_ms - launch_q;
	assign dt_c = req_q.now_ms - charge_q;

	assign in_ready = (ph_q == PH_IDLE) && !clr_q;

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			PH_IDLE:   if (in_valid && in_ready) ph_d = in_data.sensor_event ? PH_SQUARE : PH_SEQ;
			PH_SQUARE: ph_d = PH_SUM;
			PH_SUM:    ph_d = PH_ROOT;
			PH_ROOT:   if (!root_busy) ph_d = PH_WIN;
			PH_WIN:    ph_d = PH_SEQ;
			PH_SEQ:    ph_d = PH_DIV;
			PH_DIV:    ph_d = PH_OUT;
			PH_OUT:    if (!out_valid || out_ready) ph_d = PH_IDLE;
			default:   ph_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; st_q <= ST_IDLE; coast_q <= 1'b0; rec_q <= 1'b0;
			p1_q <= 1'b0; p2_q <= 1'b0; launch_q <= '0; charge_q <= '0;
			acc_q[0] <= '0; acc_q[1] <= '0; acc_q[2] <= '0; mag_q <= '0;
			ptr_q <= '0; wsum_q <= '0; clr_q <= 1'b1; clr_cnt_q <= '0;
			out_valid <= 1'b0; start_st_q <= '0;
		end else begin
			ph_q <= ph_d;
			if (ph_q == PH_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (PW+1)'(WINDOW - 1)) clr_q <= 1'b0;
			end
			case (ph_q)
				PH_IDLE: if (in_valid && in_ready) begin
					start_st_q <= st_q;
					if (in_data.sensor_event && in_data.linear_update) begin
						acc_q[0] <= in_data.accel_x; acc_q[1] <= in_data.accel_y;
						acc_q[2] <= in_data.accel_z;
					end
				end
				PH_WIN: begin
					mag_q <= root;
					wsum_q <= wsum_q - SW'(old_q) + SW'(root);
					ptr_q <= (ptr_q == PW'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
				end
				PH_SEQ: begin
					case (st_q)
						ST_IDLE: if (!req_q.switch_level) st_q <= ST_ARMED;
						ST_ARMED: if (!req_q.switch_level) st_q <= ST_LAUNCH;
							else begin st_q <= ST_IDLE; rec_q <= 1'b0; end
						ST_LAUNCH: begin
							if (ab_launch) launch_q <= req_q.now_ms;
							if (req_q.switch_level) begin st_q <= ST_ARMED; rec_q <= 1'b0; end
							else if (ab_launch) begin st_q <= ST_COAST; rec_q <= 1'b1; end
						end
						ST_COAST: begin
							if (dt_l > 32'(thr_q[CFG_COAST])) st_q <= ST_FIRE1;
							else if (!coast_q) begin
								if (dt_l > 32'(thr_q[CFG_LOCKOUT])) coast_q <= 1'b1;
							end else if (bl_apo) st_q <= ST_FIRE1;
						end
						ST_FIRE1: begin p1_q <= 1'b1; st_q <= ST_HOLD1; charge_q <= req_q.now_ms; end
						ST_HOLD1: if (dt_c > 32'(thr_q[CFG_HOLD1])) begin
							p1_q <= 1'b0; st_q <= bl_apo ? ST_FIRE2 : ST_PRESERVE;
						end
						ST_FIRE2: begin p2_q <= 1'b1; st_q <= ST_HOLD2; charge_q <= req_q.now_ms; end
						ST_HOLD2: if (dt_c > 32'(thr_q[CFG_HOLD2])) begin
							p2_q <= 1'b0; st_q <= ST_PRESERVE;
						end
						ST_PRESERVE: st_q <= ST_LANDING;
						ST_LANDING: if (bl_land) st_q <= ST_LANDED;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// average by reciprocal multiply
	assign avg_prod = (SW+32)'(wsum_q) * (SW+32)'(RECIP);
	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && in_valid && in_ready) req_q <= in_data;
		if (ph_q == PH_ROOT) old_q <= win_q[ptr_q];
		if (clr_q) win_q[clr_cnt_q[PW-1:0]] <= '0;
		else if (ph_q == PH_WIN) win_q[ptr_q] <= root;
		if (ph_q == PH_DIV) quo_q <= 16'(avg_prod >> 32);
		if (ph_q == PH_OUT && (!out_valid || out_ready)) begin
			out_data.flight_state    <= st_q;
			out_data.coast_phase     <= coast_q;
			out_data.pyro_one        <= p1_q;
			out_data.pyro_two        <= p2_q;
			out_data.baro_record     <= rec_q;
			out_data.log_enable      <= (start_st_q >= 4'd1) && (start_st_q <= 4'd9);
			out_data.accel_magnitude <= mag_q;
			out_data.accel_average   <= quo_q;
		end
	end

	`RRS_ASSERT(a_no_accept_clr, clk, arst_n, (clr_q |-> !in_ready), "accept during clear")
	`RRS_ASSERT_NEXT(a_p_excl, clk, arst_n, 1'b1, !(p1_q && p2_q), "both pyros on")
	`RRS_ASSERT(a_landed, clk, arst_n, (st_q == ST_LANDED |=> st_q == ST_LANDED), "left landed")
endmodule
`default_nettype wire

[design/rrs_square_lane.sv]
`default_nettype none
module rrs_square_lane (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] a,
	output logic [31:0]             sq_q
);
	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= 32'(a * a);
		end
	end
endmodule
`default_nettype wire

[design/rrs_root.sv]
`default_nettype none
module rrs_root (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [33:0] value,
	output logic             busy,
	output logic [15:0]      root_q
);
	logic [4:0]  cnt_q;
	logic [17:0] res_q;
	logic [35:0] rv_q;
	logic [19:0] r_q;
	logic [19:0] t;
	logic [19:0] r2;
	assign busy = (cnt_q != 5'd0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd17;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end
	assign t = {r_q[17:0], rv_q[35:34]} - {res_q[17:0], 2'b01};
	assign r2 = {r_q[17:0], rv_q[35:34]};
	always_ff @(posedge clk) begin
		if (start) begin
			rv_q  <= {value, 2'b00};
			r_q   <= '0;
			res_q <= '0;
		end else if (busy) begin
			rv_q <= {rv_q[33:0], 2'b00};
			if (!t[19]) begin
				r_q   <= t;
				res_q <= {res_q[16:0], 1'b1};
			end else begin
				r_q   <= r2;
				res_q <= {res_q[16:0], 1'b0};
			end
		end
	end
	assign root_q = res_q[15:0];
endmodule
`default_nettype wire
